@@ sv/elmg_pkg.sv @@
// Shared types and constants for the emergency latch and motion gate.
// No dependencies; imported by every module of the block.
package elmg_pkg;

    localparam int NUM_BITS   = 8;
    localparam int TIME_W     = 32;
    localparam int VEL_W      = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int POWER_W    = 15;
    localparam int MASK_OUT_W = 8;
    localparam int INDEX_W    = 3;
    localparam int MASK_PAD_W = (NUM_BITS > MASK_OUT_W) ? NUM_BITS : MASK_OUT_W;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_EMERG = 2'd1,
        OP_VEL   = 2'd2,
        OP_MOW   = 2'd3
    } elmg_op_t;

    // Register selector is paddr[2]: the two timeout registers sit at 0x0 and 0x4.
    typedef enum logic {
        REG_CMD_TIMEOUT  = 1'b0,
        REG_HARD_TIMEOUT = 1'b1
    } elmg_reg_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] safe_linear;
        logic signed [VEL_W-1:0] safe_angular;
        logic signed [VEL_W-1:0] mow_speed;
        logic                    emergency_active;
        logic                    emergency_timed;
        logic [MASK_OUT_W-1:0]   emergency_mask;
    } elmg_result_t;

endpackage

@@ sv/elmg_out_buf.sv @@
// Two-entry output buffer: an output register plus a skid register.
// Depends on elmg_pkg for the result struct.
module elmg_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  elmg_pkg::elmg_result_t push_data,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output elmg_pkg::elmg_result_t out_data
);
    import elmg_pkg::*;

    logic         head_valid_reg;
    logic         head_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    elmg_result_t head_reg;
    elmg_result_t head_next;
    elmg_result_t skid_reg;
    elmg_result_t skid_next;
    logic         pop;

    assign pop       = head_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    // The user must push only while the skid register is empty; this block does not enforce it.
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop)
        begin
            head_next       = skid_valid_reg ? skid_reg : push_data;
            head_valid_next = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held without a head entry");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg && !out_ready && push |=> skid_valid_reg)
        else $error("transaction pushed during a stall was not kept");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && skid_valid_reg |=> head_valid_reg && !skid_valid_reg)
        else $error("skid entry did not move to the head");
`endif

endmodule

@@ sv/emergency_latch_motion_gate_unit.sv @@
// A result is registered in the output buffer once its input transaction is accepted.
// Throughput: one transaction per cycle while in_ready is high; all state updates in one pass of logic.
// A two-entry output buffer keeps input accepted while output stalls, until its skid register fills.
// Reset: asynchronous, active low; clears all bits, time, commands and the buffer,
// and loads the timeouts with 50 and 1250 ticks. No clearing pass is needed.
module emergency_latch_motion_gate_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         emergency_index,
    input  logic               apply_to_all,
    input  logic               set_not_clear,
    input  logic [31:0]        duration_ticks,
    input  logic signed [15:0] linear_cmd,
    input  logic signed [15:0] angular_cmd,
    input  logic               mow_enable,
    input  logic               mow_forward,
    input  logic [14:0]        mow_magnitude,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] safe_linear,
    output logic signed [15:0] safe_angular,
    output logic signed [15:0] mow_speed,
    output logic               emergency_active,
    output logic               emergency_timed,
    output logic [7:0]         emergency_mask,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import elmg_pkg::*;

    logic                    accept;
    elmg_op_t                op;

    logic [TIMEOUT_W-1:0]    cmd_timeout_reg;
    logic [TIMEOUT_W-1:0]    hard_timeout_reg;

    // perm_reg marks set bits that have no deadline.
    logic [NUM_BITS-1:0]     mask_reg;
    logic [NUM_BITS-1:0]     mask_next;
    logic [NUM_BITS-1:0]     perm_reg;
    logic [NUM_BITS-1:0]     perm_next;
    logic [TIME_W-1:0]       deadline_reg [NUM_BITS];
    logic [TIME_W-1:0]       deadline_next [NUM_BITS];
    logic [TIME_W-1:0]       now_reg;
    logic [TIME_W-1:0]       now_next;
    logic [TIME_W-1:0]       last_cmd_reg;
    logic [TIME_W-1:0]       last_cmd_next;
    logic signed [VEL_W-1:0] last_lin_reg;
    logic signed [VEL_W-1:0] last_lin_next;
    logic signed [VEL_W-1:0] last_ang_reg;
    logic signed [VEL_W-1:0] last_ang_next;
    logic signed [VEL_W-1:0] gated_lin_reg;
    logic signed [VEL_W-1:0] gated_lin_next;
    logic signed [VEL_W-1:0] gated_ang_reg;
    logic signed [VEL_W-1:0] gated_ang_next;
    logic signed [VEL_W-1:0] mow_level_reg;
    logic signed [VEL_W-1:0] mow_level_next;

    logic [TIME_W-1:0]       now_inc;
    logic [TIME_W:0]         dl_sum;
    logic [TIME_W-1:0]       dl_sat;
    logic                    dur_zero;
    logic [NUM_BITS-1:0]     sel;
    logic [TIME_W-1:0]       elapsed;
    logic                    vel_timeout;
    logic                    hard_timeout;
    logic                    any_next;
    logic                    do_publish;
    logic signed [VEL_W-1:0] power_ext;
    logic [MASK_PAD_W-1:0]   mask_pad;
    elmg_result_t            result;
    elmg_result_t            out_data;
    logic                    cfg_write;

    assign op     = elmg_op_t'(opcode);
    assign accept = in_valid && in_ready;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (elmg_reg_t'(paddr[2]))
            REG_CMD_TIMEOUT:  prdata = PDATA_W'(cmd_timeout_reg);
            REG_HARD_TIMEOUT: prdata = PDATA_W'(hard_timeout_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_timeout_reg  <= TIMEOUT_W'(50);
            hard_timeout_reg <= TIMEOUT_W'(1250);
        end
        else if (cfg_write)
        begin
            case (elmg_reg_t'(paddr[2]))
                REG_CMD_TIMEOUT:  cmd_timeout_reg  <= pwdata[TIMEOUT_W-1:0];
                REG_HARD_TIMEOUT: hard_timeout_reg <= pwdata[TIMEOUT_W-1:0];
                default:          cmd_timeout_reg  <= cmd_timeout_reg;
            endcase
        end
    end

    // Shared arithmetic.
    assign now_inc   = (now_reg == TIME_MAX) ? now_reg : now_reg + TIME_W'(1);
    assign dl_sum    = {1'b0, now_reg} + {1'b0, duration_ticks};
    assign dl_sat    = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
    assign dur_zero  = (duration_ticks == '0);
    assign power_ext = signed'({1'b0, mow_magnitude});

    always_comb
    begin
        for (int i = 0; i < NUM_BITS; i++)
        begin
            sel[i] = apply_to_all || (int'(emergency_index) == i);
        end
    end

    // Next state for one transaction.
    always_comb
    begin
        mask_next      = mask_reg;
        perm_next      = perm_reg;
        deadline_next  = deadline_reg;
        now_next       = now_reg;
        last_cmd_next  = last_cmd_reg;
        last_lin_next  = last_lin_reg;
        last_ang_next  = last_ang_reg;
        mow_level_next = mow_level_reg;
        do_publish     = 1'b0;
        case (op)
            OP_TICK:
            begin
                now_next   = now_inc;
                do_publish = 1'b1;
                // A temporary bit expires once its deadline lies before the new time.
                for (int i = 0; i < NUM_BITS; i++)
                begin
                    if (mask_reg[i] && !perm_reg[i] && (deadline_reg[i] < now_inc))
                    begin
                        mask_next[i] = 1'b0;
                    end
                end
            end
            OP_EMERG:
            begin
                do_publish = 1'b1;
                for (int i = 0; i < NUM_BITS; i++)
                begin
                    if (sel[i])
                    begin
                        if (set_not_clear)
                        begin
                            // A timed set leaves a latched bit latched.
                            if (!(perm_reg[i] && mask_reg[i] && !dur_zero))
                            begin
                                perm_next[i]     = dur_zero;
                                deadline_next[i] = dl_sat;
                            end
                            mask_next[i] = 1'b1;
                        end
                        else
                        begin
                            mask_next[i] = 1'b0;
                            perm_next[i] = 1'b0;
                        end
                    end
                end
            end
            OP_VEL:
            begin
                last_lin_next = linear_cmd;
                last_ang_next = angular_cmd;
                last_cmd_next = now_reg;
            end
            OP_MOW:
            begin
                if (mow_enable && (mask_reg == '0))
                begin
                    mow_level_next = mow_forward ? power_ext : -power_ext;
                end
                else
                begin
                    mow_level_next = '0;
                end
            end
            default:
            begin
                do_publish = 1'b0;
            end
        endcase
    end

    // Gate publication, using the time and bits after this transaction.
    assign any_next     = (mask_next != '0);
    assign elapsed      = now_next - last_cmd_reg;
    assign vel_timeout  = (elapsed > TIME_W'(cmd_timeout_reg));
    assign hard_timeout = (elapsed > TIME_W'(hard_timeout_reg));

    always_comb
    begin
        gated_lin_next = gated_lin_reg;
        gated_ang_next = gated_ang_reg;
        if (do_publish)
        begin
            if (any_next || vel_timeout || hard_timeout)
            begin
                gated_lin_next = '0;
                gated_ang_next = '0;
            end
            else
            begin
                gated_lin_next = last_lin_reg;
                gated_ang_next = last_ang_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            perm_reg      <= '0;
            now_reg       <= '0;
            last_cmd_reg  <= '0;
            last_lin_reg  <= '0;
            last_ang_reg  <= '0;
            gated_lin_reg <= '0;
            gated_ang_reg <= '0;
            mow_level_reg <= '0;
        end
        else if (accept)
        begin
            mask_reg      <= mask_next;
            perm_reg      <= perm_next;
            now_reg       <= now_next;
            last_cmd_reg  <= last_cmd_next;
            last_lin_reg  <= last_lin_next;
            last_ang_reg  <= last_ang_next;
            gated_lin_reg <= gated_lin_next;
            gated_ang_reg <= gated_ang_next;
            if (do_publish && (any_next || hard_timeout))
            begin
                mow_level_reg <= '0;
            end
            else
            begin
                mow_level_reg <= mow_level_next;
            end
        end
    end

    // Deadlines are only read while their bit is set as temporary.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            deadline_reg <= deadline_next;
        end
    end

    // Result of this transaction.
    assign mask_pad = MASK_PAD_W'(mask_next);

    always_comb
    begin
        result.safe_linear      = gated_lin_next;
        result.safe_angular     = gated_ang_next;
        result.mow_speed        = (do_publish && (any_next || hard_timeout)) ?
                                  '0 : mow_level_next;
        result.emergency_active = any_next;
        result.emergency_timed  = ((mask_next & perm_next) == '0);
        result.emergency_mask   = mask_pad[MASK_OUT_W-1:0];
    end

    elmg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign safe_linear      = out_data.safe_linear;
    assign safe_angular     = out_data.safe_angular;
    assign mow_speed        = out_data.mow_speed;
    assign emergency_active = out_data.emergency_active;
    assign emergency_timed  = out_data.emergency_timed;
    assign emergency_mask   = out_data.emergency_mask;

`ifndef SYNTHESIS
    a_latched_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (perm_reg & ~mask_reg) == '0)
        else $error("latched flag on a bit that is not set");

    a_mow_off_in_emergency: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg != '0) |-> (mow_level_reg == '0))
        else $error("mow motor running during an emergency");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_TICK) && (now_reg != TIME_MAX)
        |=> now_reg == $past(now_reg) + TIME_W'(1))
        else $error("tick did not advance the time counter");
`endif

endmodule
